// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed.");

`endif

// ===== sv/pse_pkg.sv =====
package pse_pkg;

    localparam int LIMIT_W   = 17;
    localparam int PRIME_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 17'h10000;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 1'd0;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_CLR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT,
        ST_MARK
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic restart;
        logic scan_read;
        logic hit_set;
        logic hit_clear;
        logic load_out;
        logic mark_load;
        logic mark_step;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic dirty;
        logic cursor_lt_lim;
        logic cand_free;
        logic hit;
        logic sq_lt_lim;
        logic m_lt_lim;
        logic out_free;
    } status_t;

endpackage

// ===== sv/prime_sieve_engine.sv =====
// Each request transaction yields exactly one response transaction: the next prime below the
// limit register with a running count, or found low once the sieve is exhausted. A request is
// accepted in an idle cycle; each number scanned is first read from the bitmap and then checked,
// and the result is loaded into the response register once that register is free. When a prime
// is found, its multiples from its square upward are then marked at one per cycle, and requests
// stay stalled until marking ends. All of this is set by the composite bitmap and its single
// write port. After reset, and on a restart once any number has been marked, the bitmap is
// swept clear at one bit per cycle while requests are stalled.
module prime_sieve_engine #(
    parameter int MAX_LIMIT = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pse_pkg::ADDR_W-1:0]    paddr,
    input  logic [pse_pkg::DATA_W-1:0]    pwdata,
    output logic [pse_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          restart,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [pse_pkg::PRIME_W-1:0]   prime,
    output logic                          found,
    output logic [pse_pkg::COUNT_W-1:0]   prime_count
);
    import pse_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               limit_sel;
    cmd_t               cmd;
    status_t            status;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[ADDR_W-1:2] == REG_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && limit_sel)
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = limit_sel ? DATA_W'(limit_reg) : '0;

    pse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .restart   (restart),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pse_dpath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit_reg),
        .cmd         (cmd),
        .status      (status),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .prime       (prime),
        .found       (found),
        .prime_count (prime_count)
    );

endmodule

// ===== sv/pse_ctrl.sv =====
module pse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             restart,
    output logic             req_stall,
    input  pse_pkg::status_t status,
    output pse_pkg::cmd_t    cmd
);
    import pse_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_INIT_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (restart)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = status.dirty ? ST_CLR : ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (status.cursor_lt_lim)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_SCAN_CHK;
                end
                else
                begin
                    cmd.hit_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_SCAN_CHK:
            begin
                if (status.cand_free)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.hit && status.sq_lt_lim)
                    begin
                        cmd.mark_load = 1'b1;
                        state_next    = ST_MARK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                if (status.m_lt_lim)
                begin
                    cmd.mark_step = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pse_dpath.sv =====
module pse_dpath #(
    parameter int MAX_LIMIT = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pse_pkg::LIMIT_W-1:0]   limit,
    input  pse_pkg::cmd_t                 cmd,
    output pse_pkg::status_t              status,
    input  logic                          rsp_stall,
    output logic                          rsp_valid,
    output logic [pse_pkg::PRIME_W-1:0]   prime,
    output logic                          found,
    output logic [pse_pkg::COUNT_W-1:0]   prime_count
);
    import pse_pkg::*;

    localparam int AW = $clog2(MAX_LIMIT);
    localparam int CW = $clog2(MAX_LIMIT + 1);
    localparam int PW = 2 * AW;
    localparam int MW = CW + 1;
    localparam logic [31:0]   MAX_LIMIT_W = 32'(MAX_LIMIT);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(MAX_LIMIT - 1);

    logic map_mem [MAX_LIMIT];

    logic [31:0]        lim_wide;
    logic [CW-1:0]      lim;

    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      clr_next;
    logic               dirty_reg;
    logic               dirty_next;
    logic [CW-1:0]      cursor_reg;
    logic [CW-1:0]      cursor_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               hit_reg;
    logic               hit_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    logic               rd_data_reg;
    logic [AW-1:0]      p_reg;
    logic [AW-1:0]      p_next;
    logic [PW-1:0]      sq_reg;
    logic [PW-1:0]      sq_next;
    logic [MW-1:0]      m_reg;
    logic [MW-1:0]      m_next;
    logic [PRIME_W-1:0] prime_reg;
    logic [PRIME_W-1:0] prime_next;
    logic               found_reg;
    logic               found_next;
    logic [COUNT_W-1:0] pcount_reg;
    logic [COUNT_W-1:0] pcount_next;

    assign lim_wide = (32'(limit) > MAX_LIMIT_W) ? MAX_LIMIT_W : 32'(limit);
    assign lim      = lim_wide[CW-1:0];

    assign status.clr_last      = (clr_reg == LAST_ADDR);
    assign status.dirty         = dirty_reg;
    assign status.cursor_lt_lim = (cursor_reg < lim);
    assign status.cand_free     = !rd_data_reg;
    assign status.hit           = hit_reg;
    assign status.sq_lt_lim     = (sq_reg < PW'(lim));
    assign status.m_lt_lim      = (m_reg < MW'(lim));
    assign status.out_free      = !rsp_valid_reg || !rsp_stall;

    // The bitmap has a single write port shared by the clearing sweep and marking.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            map_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.mark_step)
        begin
            map_mem[m_reg[AW-1:0]] <= 1'b1;
        end
        if (cmd.scan_read)
        begin
            rd_data_reg <= map_mem[cursor_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        clr_next       = clr_reg;
        dirty_next     = dirty_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        m_next         = m_reg;
        prime_next     = prime_reg;
        found_next     = found_reg;
        pcount_next    = pcount_reg;

        if (cmd.clr_en)
        begin
            clr_next = status.clr_last ? '0 : AW'(clr_reg + 1'b1);
            if (status.clr_last)
            begin
                dirty_next = 1'b0;
            end
        end
        if (cmd.mark_step)
        begin
            dirty_next = 1'b1;
            m_next     = m_reg + MW'(p_reg);
        end
        if (cmd.mark_load)
        begin
            m_next = MW'(sq_reg);
        end

        if (cmd.restart)
        begin
            cursor_next = CW'(2);
            count_next  = '0;
        end
        else if (cmd.scan_read)
        begin
            cursor_next = CW'(cursor_reg + 1'b1);
            p_next      = cursor_reg[AW-1:0];
        end

        if (cmd.hit_set)
        begin
            hit_next = 1'b1;
            sq_next  = PW'(p_reg) * PW'(p_reg);
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.hit_clear)
        begin
            hit_next = 1'b0;
        end

        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
            prime_next     = hit_reg ? PRIME_W'(p_reg) : '0;
            found_next     = hit_reg;
            pcount_next    = count_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            dirty_reg     <= 1'b1;
            cursor_reg    <= CW'(2);
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            dirty_reg     <= dirty_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        sq_reg     <= sq_next;
        m_reg      <= m_next;
        prime_reg  <= prime_next;
        found_reg  <= found_next;
        pcount_reg <= pcount_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign prime       = prime_reg;
    assign found       = found_reg;
    assign prime_count = pcount_reg;

endmodule

// ===== sv/pse_checker.sv =====
`include "assert_macros.svh"

module pse_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [pse_pkg::ADDR_W-1:0]    paddr,
    input logic [pse_pkg::DATA_W-1:0]    pwdata,
    input logic [pse_pkg::DATA_W-1:0]    prdata,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [pse_pkg::PRIME_W-1:0]   prime,
    input logic                          found,
    input logic [pse_pkg::COUNT_W-1:0]   prime_count
);
    import pse_pkg::*;

    logic                           rsp_hold;
    logic [PRIME_W+COUNT_W:0]       rsp_word;
    logic                           cfg_wr;
    logic                           cfg_rd;
    logic [LIMIT_W-1:0]             wr_lim;
    logic [LIMIT_W-1:0]             rd_lim;

    assign rsp_hold = rsp_valid && rsp_stall;
    assign rsp_word = {prime, found, prime_count};
    assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_LIMIT);
    assign cfg_rd   = psel && !pwrite && (paddr[ADDR_W-1:2] == REG_LIMIT);
    assign wr_lim   = pwdata[LIMIT_W-1:0];
    assign rd_lim   = prdata[LIMIT_W-1:0];

    `ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_hold, rsp_valid)
    `ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_hold, $stable(rsp_word))
    `ASSERT_IMPLIES(a_empty_prime, clk, rst_n, rsp_valid && !found, prime == '0)
    `ASSERT_IMPLIES(a_limit_readback, clk, rst_n, cfg_wr ##1 cfg_rd, rd_lim == $past(wr_lim))

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (.*);

// ===== tb/sv/prime_sieve_engine_tb.sv =====
module prime_sieve_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int SIEVE_SPAN      = 65536;
    localparam int FIRST_CANDIDATE = 2;
    localparam int COUNT_CEILING   = 65535;
    localparam int TOTAL_ITEMS     = 1650;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 136;
    localparam int SETTLE_MARGIN   = 100;
    localparam int WATCHDOG_LIMIT  = 300000;
    localparam int LIMIT_FIELD_MAX = 131071;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic               found;
        logic [COUNT_W-1:0] count;
    } prime_result_t;

    class prime_scoreboard;
        bit                     sieved_out[SIEVE_SPAN];
        int unsigned            cursor;
        int unsigned            primes_seen;
        int unsigned            limit_reg;
        int unsigned            tail_marks;
        int unsigned            failures;
        prime_result_t          pending_primes[$];

        function new();
            clear_sieve();
            limit_reg  = SIEVE_SPAN;
            tail_marks = 0;
            failures   = 0;
        endfunction

        function void clear_sieve();
            foreach (sieved_out[i])
            begin
                sieved_out[i] = 1'b0;
            end
            cursor      = FIRST_CANDIDATE;
            primes_seen = 0;
        endfunction

        function void set_limit(input int unsigned value);
            limit_reg = value & LIMIT_FIELD_MAX;
        endfunction

        function int unsigned outstanding();
            return pending_primes.size();
        endfunction

        function int unsigned mark_backlog();
            return tail_marks;
        endfunction

        function void predict_next_prime(input bit restart_req);
            int unsigned     lim;
            int unsigned     cand;
            int unsigned     p;
            bit              hit;
            longint unsigned m;
            prime_result_t   want;
            lim = (limit_reg > SIEVE_SPAN) ? SIEVE_SPAN : limit_reg;
            p = 0;
            hit = 1'b0;
            tail_marks = 0;
            if (restart_req)
            begin
                clear_sieve();
            end
            while (cursor < lim)
            begin
                cand = cursor;
                cursor++;
                if (!sieved_out[cand])
                begin
                    p = cand;
                    hit = 1'b1;
                    break;
                end
            end
            if (hit)
            begin
                if (primes_seen < COUNT_CEILING)
                begin
                    primes_seen++;
                end
                for (m = longint'(p) * longint'(p); m < lim; m += p)
                begin
                    sieved_out[m] = 1'b1;
                    tail_marks++;
                end
            end
            want.prime = hit ? p[PRIME_W-1:0] : '0;
            want.found = hit;
            want.count = primes_seen[COUNT_W-1:0];
            pending_primes.push_back(want);
        endfunction

        function void check_prime(input logic [PRIME_W-1:0] prime, input logic found,
                                  input logic [COUNT_W-1:0] count);
            prime_result_t want;
            if (pending_primes.size() == 0)
            begin
                failures++;
                $error("Response transaction with no request outstanding: prime %0d", prime);
                return;
            end
            want = pending_primes.pop_front();
            if (prime !== want.prime)
            begin
                failures++;
                $error("prime: expected %0d, actual %0d", want.prime, prime);
            end
            if (found !== want.found)
            begin
                failures++;
                $error("found: expected %0d, actual %0d", want.found, found);
            end
            if (count !== want.count)
            begin
                failures++;
                $error("prime_count: expected %0d, actual %0d", want.count, count);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                restart   = 1'b0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [PRIME_W-1:0]  prime;
    logic                found;
    logic [COUNT_W-1:0]  prime_count;

    prime_scoreboard     board = new();
    int unsigned         items_sent    = 0;
    int unsigned         send_gap_pct  = 27;
    int unsigned         rsp_hold_pct  = 55;
    int unsigned         quiet_cycles  = 0;

    prime_sieve_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .restart     (restart),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .prime       (prime),
        .found       (found),
        .prime_count (prime_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_stall = ($urandom_range(99) < rsp_hold_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            board.check_prime(prime, found, prime_count);
        end
    end

    // Counts cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** prime_sieve_engine: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function void update_idling();
        if (items_sent < TOTAL_ITEMS / 3)
        begin
            send_gap_pct = 27;
            rsp_hold_pct = 55;
        end
        else if (items_sent < 2 * TOTAL_ITEMS / 3)
        begin
            send_gap_pct = 55;
            rsp_hold_pct = 27;
        end
        else
        begin
            send_gap_pct = 0;
            rsp_hold_pct = 0;
        end
    endfunction

    function automatic int unsigned pick_limit();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            return $urandom_range(4);
        end
        else if (sel < 55)
        begin
            return $urandom_range(300, 5);
        end
        else if (sel < 82)
        begin
            return $urandom_range(4096, 301);
        end
        else if (sel < 91)
        begin
            return SIEVE_SPAN;
        end
        return $urandom_range(LIMIT_FIELD_MAX, SIEVE_SPAN + 1);
    endfunction

    task automatic send_request(input bit restart_req);
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            restart   = 1'($urandom);
        end
        @(negedge clk);
        req_valid = 1'b1;
        restart   = restart_req;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        board.predict_next_prime(restart_req);
        items_sent++;
        update_idling();
    endtask

    // With settle set, the wait also covers the marking that follows the last result.
    task automatic drain_responses(input bit settle);
        @(negedge clk);
        req_valid = 1'b0;
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
        if (settle)
        begin
            repeat (board.mark_backlog() + SETTLE_MARGIN) @(posedge clk);
        end
    endtask

    task automatic write_limit(input int unsigned value);
        drain_responses(1'b1);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_LIMIT, 2'b00};
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        board.set_limit(value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        int unsigned burst;
        bit          restart_req;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_limit(0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        write_limit(1);
        send_request(1'b0);
        write_limit(2);
        send_request(1'b0);
        write_limit(3);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        // Raising the limit without a restart lets an unmarked composite through.
        write_limit(LIMIT_FIELD_MAX);
        send_request(1'b0);
        write_limit(SIEVE_SPAN);
        send_request(1'b0);
        send_request(1'b0);
        write_limit(12);
        send_request(1'b1);
        repeat (5) send_request(1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_limit(pick_limit());
            burst = (phase == RANDOM_PHASES - 1) ? TOTAL_ITEMS - items_sent : PHASE_ITEMS;
            for (int i = 0; i < burst; i++)
            begin
                restart_req = (i == 0) && ($urandom_range(99) < 35);
                if ($urandom_range(99) == 0)
                begin
                    drain_responses(1'b0);
                end
                send_request(restart_req);
            end
        end

        drain_responses(1'b1);
        if (board.failures == 0)
        begin
            $display("** prime_sieve_engine: PASSED **");
        end
        else
        begin
            $display("** prime_sieve_engine: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pse_pkg.sv
sv/pse_ctrl.sv
sv/pse_dpath.sv
sv/prime_sieve_engine.sv
sv/pse_checker.sv
tb/sv/prime_sieve_engine_tb.sv
